>>> hdl/cep_pkg.sv
// Shared constants and tables of the covariance ellipse point generator.
package cep_pkg;

   localparam int NUM_POINTS_DEF = 40;
   localparam int IDX_W          = 6;
   localparam int CHI_W          = 24;
   localparam int TOL_W          = 16;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 24;
   localparam int REQ_DATA_W     = 224;
   localparam int RSP_DATA_W     = 104;

   localparam logic [CHI_W-1:0] CHI_RESET = 24'd603608;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd0;

   localparam logic [CSR_IDX_W-1:0] REG_CHI_SCALE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYM_TOL   = 1'd1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ASYM    = 2'd1;
   localparam logic [1:0] ST_NOT_PSD = 2'd2;

   localparam int CORDIC_STEPS = 28;
   localparam int SC_LAT       = CORDIC_STEPS + 2;
   localparam int SQRT_STEPS   = 32;
   localparam int SC_W         = 34;
   localparam int AT_W         = 60;

   localparam logic signed [SC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

   localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
   localparam logic [31:0] ANG_HALF    = 32'h8000_0000;
   localparam logic [31:0] ANG_3QUART  = 32'hC000_0000;

   // atan(2^-i) as a binary angle with 2^32 for a full turn.
   localparam logic [31:0] ATAN_BAM [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5};

endpackage

>>> hdl/cep_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module cep_isqrt
   import cep_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);

   logic [33:0] rem_ff  [1:SQRT_STEPS];
   logic [31:0] root_ff [1:SQRT_STEPS];
   logic [63:0] rest_ff [1:SQRT_STEPS];
   logic [33:0] rem_in  [1:SQRT_STEPS];
   logic [31:0] root_in [1:SQRT_STEPS];
   logic [63:0] rest_in [1:SQRT_STEPS];

   always_comb begin
      logic [33:0] rem_s;
      logic [31:0] root_s;
      logic [63:0] rest_s;
      logic [35:0] rem4;
      logic [35:0] trial;
      for (int j = 0; j < SQRT_STEPS; j++) begin
         if (j == 0) begin
            rem_s  = '0;
            root_s = '0;
            rest_s = rad;
         end else begin
            rem_s  = rem_ff[j];
            root_s = root_ff[j];
            rest_s = rest_ff[j];
         end
         rem4  = {rem_s, rest_s[63:62]};
         trial = {2'b00, root_s, 2'b01};
         if (rem4 >= trial) begin
            rem_in[j+1]  = 34'(rem4 - trial);
            root_in[j+1] = {root_s[30:0], 1'b1};
         end else begin
            rem_in[j+1]  = 34'(rem4);
            root_in[j+1] = {root_s[30:0], 1'b0};
         end
         rest_in[j+1] = {rest_s[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 1; j <= SQRT_STEPS; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            rest_ff[j] <= rest_in[j];
         end
      end
   end

   assign root = root_ff[SQRT_STEPS];

endmodule

>>> hdl/cep_sincos.sv
// Pipelined rotation CORDIC giving cosine and sine of a binary angle in Q2.30.
module cep_sincos
   import cep_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        angle,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);

   logic signed [SC_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [SC_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [SC_W-1:0] z_ff [CORDIC_STEPS+1];
   logic                   flip_ff [CORDIC_STEPS+1];
   logic signed [SC_W-1:0] x_in [CORDIC_STEPS+1];
   logic signed [SC_W-1:0] y_in [CORDIC_STEPS+1];
   logic signed [SC_W-1:0] z_in [CORDIC_STEPS+1];
   logic                   flip_in [CORDIC_STEPS+1];
   logic signed [31:0]     cos_ff, sin_ff;

   always_comb begin
      logic [31:0] tq;
      logic [31:0] tr;
      // Angles in the left half plane are turned by half a turn and the result negated.
      tq         = angle + ANG_QUARTER;
      flip_in[0] = tq[31];
      tr         = tq[31] ? angle - ANG_HALF : angle;
      z_in[0]    = SC_W'($signed(tr));
      x_in[0]    = CORDIC_INV_GAIN;
      y_in[0]    = '0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         flip_in[i+1] = flip_ff[i];
         if (!z_ff[i][SC_W-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - SC_W'(ATAN_BAM[i]);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + SC_W'(ATAN_BAM[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            flip_ff[i] <= flip_in[i];
         end
         cos_ff <= 32'(flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS]);
         sin_ff <= 32'(flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS]);
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

>>> hdl/covariance_ellipse_points.sv
// Top level of the covariance confidence ellipse contour point generator.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  req_     | in        | mean x/y/z and the four covariance entries
//  rsp_     | out       | one contour point or one error result
//  csr_     | in        | write of chi_square_scale or symmetry_tolerance
//
// A valid item gives NUM_POINTS+1 response beats, one per cycle while the output
// is not stalled; an item that fails a check gives one beat. An accepted beat
// passes the check stages, three square roots and two CORDICs to reach the point
// generator; each point then passes a sine/cosine CORDIC and the multiply stages.
// Reset is synchronous and clears all valid bits, the generator and the two
// registers. A low rsp_tready freezes the point pipeline; the item pipeline
// freezes while its last stage holds an item the generator cannot yet take.
module covariance_ellipse_points
   import cep_pkg::*;
#(
   parameter int NUM_POINTS = NUM_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mean_x, mean_y, mean_z, cov_xx, cov_yy, cov_xy, cov_yx
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // point_x, point_y, point_z, point_index, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // status
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [63:0]      TWO32   = 64'd1 << 32;
   localparam int               FR_W    = $clog2(NUM_POINTS) + 1;
   localparam logic [31:0]      T_STEP  = 32'(TWO32 / NUM_POINTS);
   localparam logic [FR_W-1:0]  T_FRAC  = FR_W'(TWO32 % NUM_POINTS);
   localparam logic [FR_W-1:0]  N_FR    = FR_W'(NUM_POINTS);
   localparam logic [IDX_W-1:0] K_LAST  = IDX_W'(NUM_POINTS);

   typedef struct packed {
      logic               vld;
      logic [1:0]         status;
      logic signed [31:0] mx, my, mz, sxx, syy, sxy, syx;
      logic signed [32:0] d, tr;
      logic [32:0]        ud;
      logic [31:0]        us;
      logic signed [63:0] det1, det2;
      logic [63:0]        d2, q, rad;
      logic [32:0]        la, lb;
      logic [63:0]        pa, pb;
      logic [31:0]        a, b, phi;
      logic signed [31:0] ca, sa;
   } item_type;

   typedef struct packed {
      logic               vld;
      logic               last;
      logic [1:0]         status;
      logic [IDX_W-1:0]   k;
      logic [31:0]        t, a, b;
      logic signed [31:0] ca, sa, mx, my, mz;
      logic signed [63:0] ua, vb;
      logic signed [31:0] uu, vv;
      logic signed [63:0] xa, xb, ya, yb;
      logic signed [33:0] xi, yi;
      logic [31:0]        px, py;
   } pt_type;

   logic [CHI_W-1:0] chi_ff;
   logic [TOL_W-1:0] tol_ff;
   logic fe, pe, take, fin;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         chi_ff <= CHI_RESET;
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CHI_SCALE: chi_ff <= csr_wdata[CHI_W-1:0];
            REG_SYM_TOL:   tol_ff <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- item pipeline: checks and radicand ----------------
   item_type s0_ff, s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, fo_ff;
   item_type s0_in, s1_in, s2_in, s3_in, s4_in, s5_in, s6_in, s7_in, fo_in;

   assign req_tready = fe;

   always_comb begin
      s0_in        = '0;
      s0_in.vld    = req_tvalid;
      s0_in.mx     = req_tdata[31:0];
      s0_in.my     = req_tdata[63:32];
      s0_in.mz     = req_tdata[95:64];
      s0_in.sxx    = req_tdata[127:96];
      s0_in.syy    = req_tdata[159:128];
      s0_in.sxy    = req_tdata[191:160];
      s0_in.syx    = req_tdata[223:192];
   end

   always_comb begin
      logic signed [32:0] dif;
      logic [32:0]        adiff;
      s1_in   = s0_ff;
      dif     = 33'(s0_ff.sxy) - 33'(s0_ff.syx);
      adiff   = 33'(dif < 0 ? -dif : dif);
      s1_in.d = 33'(s0_ff.sxx) - 33'(s0_ff.syy);
      s1_in.tr = 33'(s0_ff.sxx) + 33'(s0_ff.syy);
      s1_in.ud = 33'(s1_in.d < 0 ? -s1_in.d : s1_in.d);
      s1_in.us = 32'(s0_ff.sxy < 0 ? -s0_ff.sxy : s0_ff.sxy);
      s1_in.status = (adiff > 33'(tol_ff)) ? ST_ASYM : ST_OK;
   end

   always_comb begin
      logic signed [63:0] m1, m2;
      logic [65:0]        m3;
      logic [63:0]        m4;
      s2_in      = s1_ff;
      m1         = s1_ff.sxx * s1_ff.syy;
      m2         = s1_ff.syx * s1_ff.sxy;
      m3         = s1_ff.ud * s1_ff.ud;
      m4         = s1_ff.us * s1_ff.us;
      s2_in.det1 = m1;
      s2_in.det2 = m2;
      s2_in.d2   = m3[63:0];
      s2_in.q    = m4;
   end

   always_comb begin
      logic signed [64:0] det;
      logic [65:0]        sum;
      s3_in = s2_ff;
      det   = 65'(s2_ff.det1) - 65'(s2_ff.det2);
      sum   = {2'b00, s2_ff.d2} + {s2_ff.q, 2'b00};
      s3_in.rad = (sum[65:64] != 2'b00) ? '1 : sum[63:0];
      if (s2_ff.status == ST_OK &&
          (det < 0 || !(s2_ff.sxx > 0 || s2_ff.syy > 0)))
         s3_in.status = ST_NOT_PSD;
   end

   // ---------------- eigenvalues and half axes ----------------
   item_type    dl_r_ff  [SQRT_STEPS];
   item_type    dl_ab_ff [SQRT_STEPS];
   logic [31:0] r_root, a_root, b_root;

   cep_isqrt u_sqrt_r (.clock(clock), .en(fe), .rad(s3_ff.rad), .root(r_root));

   always_comb begin
      logic signed [34:0] sp, sm;
      s4_in = dl_r_ff[SQRT_STEPS-1];
      sp    = 35'(s4_in.tr) + $signed({3'b000, r_root});
      sm    = 35'(s4_in.tr) - $signed({3'b000, r_root});
      // Halving rounds toward minus infinity; negative eigenvalues clamp to zero.
      s4_in.la = sp[34] ? '0 : sp[33:1];
      s4_in.lb = sm[34] ? '0 : sm[33:1];
   end

   always_comb begin
      logic [56:0] ma, mb;
      s5_in    = s4_ff;
      ma       = chi_ff * s4_ff.la;
      mb       = chi_ff * s4_ff.lb;
      s5_in.pa = 64'(ma);
      s5_in.pb = 64'(mb);
   end

   cep_isqrt u_sqrt_a (.clock(clock), .en(fe), .rad(s5_ff.pa), .root(a_root));
   cep_isqrt u_sqrt_b (.clock(clock), .en(fe), .rad(s5_ff.pb), .root(b_root));

   always_comb begin
      s6_in   = dl_ab_ff[SQRT_STEPS-1];
      s6_in.a = a_root;
      s6_in.b = b_root;
   end

   // ---------------- orientation: vectoring CORDIC ----------------
   item_type               at_item_ff [CORDIC_STEPS+1];
   logic signed [AT_W-1:0] at_x_ff [CORDIC_STEPS+1];
   logic signed [AT_W-1:0] at_y_ff [CORDIC_STEPS+1];
   logic [31:0]            at_z_ff [CORDIC_STEPS+1];
   logic                   at_sp_ff [CORDIC_STEPS+1];
   logic [31:0]            at_spz_ff [CORDIC_STEPS+1];
   logic signed [AT_W-1:0] at_x_in [CORDIC_STEPS+1];
   logic signed [AT_W-1:0] at_y_in [CORDIC_STEPS+1];
   logic [31:0]            at_z_in [CORDIC_STEPS+1];
   logic                   at_sp_in;
   logic [31:0]            at_spz_in;

   always_comb begin
      logic signed [33:0]     y0;
      logic signed [32:0]     x0;
      logic signed [AT_W-1:0] xe, ye;
      y0 = 34'(s6_ff.sxy) <<< 1;
      x0 = s6_ff.d;
      // Axis-aligned and zero vectors get their angle directly.
      if (y0 == 0) begin
         at_sp_in  = 1'b1;
         at_spz_in = (x0 < 0) ? ANG_HALF : '0;
      end else if (x0 == 0) begin
         at_sp_in  = 1'b1;
         at_spz_in = (y0 > 0) ? ANG_QUARTER : ANG_3QUART;
      end else begin
         at_sp_in  = 1'b0;
         at_spz_in = '0;
      end
      xe         = AT_W'(x0);
      ye         = AT_W'(y0);
      at_z_in[0] = '0;
      if (x0 < 0) begin
         xe         = -xe;
         ye         = -ye;
         at_z_in[0] = ANG_HALF;
      end
      at_x_in[0] = xe <<< 24;
      at_y_in[0] = ye <<< 24;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (at_y_ff[i] > 0) begin
            at_x_in[i+1] = at_x_ff[i] + (at_y_ff[i] >>> i);
            at_y_in[i+1] = at_y_ff[i] - (at_x_ff[i] >>> i);
            at_z_in[i+1] = at_z_ff[i] + ATAN_BAM[i];
         end else begin
            at_x_in[i+1] = at_x_ff[i] - (at_y_ff[i] >>> i);
            at_y_in[i+1] = at_y_ff[i] + (at_x_ff[i] >>> i);
            at_z_in[i+1] = at_z_ff[i] - ATAN_BAM[i];
         end
      end
   end

   always_comb begin
      logic [31:0] zf;
      s7_in = at_item_ff[CORDIC_STEPS];
      zf    = at_sp_ff[CORDIC_STEPS] ? at_spz_ff[CORDIC_STEPS] : at_z_ff[CORDIC_STEPS];
      s7_in.phi = (zf <= ANG_HALF) ? {1'b0, zf[31:1]} : {1'b0, zf[31:1]} + ANG_HALF;
   end

   item_type           dl_sc_ff [SC_LAT];
   logic signed [31:0] phi_cos, phi_sin;

   cep_sincos u_sincos_phi (
      .clock(clock), .en(fe), .angle(s7_ff.phi), .cos_out(phi_cos), .sin_out(phi_sin));

   always_comb begin
      fo_in    = dl_sc_ff[SC_LAT-1];
      fo_in.ca = phi_cos;
      fo_in.sa = phi_sin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0;
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
         s5_ff.vld <= 1'b0;
         s6_ff.vld <= 1'b0;
         s7_ff.vld <= 1'b0;
         fo_ff.vld <= 1'b0;
         for (int j = 0; j < SQRT_STEPS; j++) begin
            dl_r_ff[j].vld  <= 1'b0;
            dl_ab_ff[j].vld <= 1'b0;
         end
         for (int j = 0; j <= CORDIC_STEPS; j++) at_item_ff[j].vld <= 1'b0;
         for (int j = 0; j < SC_LAT; j++) dl_sc_ff[j].vld <= 1'b0;
      end else if (fe) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         fo_ff <= fo_in;
         dl_r_ff[0]  <= s3_ff;
         dl_ab_ff[0] <= s5_ff;
         for (int j = 1; j < SQRT_STEPS; j++) begin
            dl_r_ff[j]  <= dl_r_ff[j-1];
            dl_ab_ff[j] <= dl_ab_ff[j-1];
         end
         at_item_ff[0] <= s6_ff;
         for (int j = 1; j <= CORDIC_STEPS; j++) at_item_ff[j] <= at_item_ff[j-1];
         dl_sc_ff[0] <= s7_ff;
         for (int j = 1; j < SC_LAT; j++) dl_sc_ff[j] <= dl_sc_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         at_sp_ff[0]  <= at_sp_in;
         at_spz_ff[0] <= at_spz_in;
         for (int j = 0; j <= CORDIC_STEPS; j++) begin
            at_x_ff[j] <= at_x_in[j];
            at_y_ff[j] <= at_y_in[j];
            at_z_ff[j] <= at_z_in[j];
         end
         for (int j = 1; j <= CORDIC_STEPS; j++) begin
            at_sp_ff[j]  <= at_sp_ff[j-1];
            at_spz_ff[j] <= at_spz_ff[j-1];
         end
      end
   end

   // ---------------- point generator ----------------
   item_type         g_ff;
   logic             busy_ff;
   logic [IDX_W-1:0] k_ff;
   logic [31:0]      t_ff, t_in;
   logic [FR_W-1:0]  frac_ff, frac_in;
   pt_type           p0_ff, p0_in;

   always_comb begin
      logic [FR_W-1:0] fsum;
      fin  = busy_ff && (k_ff == K_LAST || g_ff.status != ST_OK);
      take = pe && fo_ff.vld && (!busy_ff || fin);
      fe   = !fo_ff.vld || take;
      // The contour angle advances by 2^32/NUM_POINTS with an exact remainder.
      fsum = frac_ff + T_FRAC;
      if (fsum >= N_FR) begin
         frac_in = fsum - N_FR;
         t_in    = t_ff + T_STEP + 32'd1;
      end else begin
         frac_in = fsum;
         t_in    = t_ff + T_STEP;
      end
      p0_in        = '0;
      p0_in.vld    = busy_ff;
      p0_in.last   = fin;
      p0_in.status = g_ff.status;
      p0_in.k      = k_ff;
      p0_in.t      = t_ff;
      p0_in.a      = g_ff.a;
      p0_in.b      = g_ff.b;
      p0_in.ca     = g_ff.ca;
      p0_in.sa     = g_ff.sa;
      p0_in.mx     = g_ff.mx;
      p0_in.my     = g_ff.my;
      p0_in.mz     = g_ff.mz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         k_ff      <= '0;
         t_ff      <= '0;
         frac_ff   <= '0;
         p0_ff.vld <= 1'b0;
      end else if (pe) begin
         p0_ff <= p0_in;
         if (take) begin
            g_ff    <= fo_ff;
            busy_ff <= 1'b1;
            k_ff    <= '0;
            t_ff    <= '0;
            frac_ff <= '0;
         end else if (busy_ff) begin
            if (fin) busy_ff <= 1'b0;
            k_ff    <= k_ff + 1'b1;
            t_ff    <= t_in;
            frac_ff <= frac_in;
         end
      end
   end

   // ---------------- point pipeline ----------------
   pt_type             pd_ff [SC_LAT];
   pt_type             q1_ff, q2_ff, q3_ff, q4_ff, out_ff;
   pt_type             q1_in, q2_in, q3_in, q4_in, out_in;
   logic signed [31:0] pt_cos, pt_sin;

   cep_sincos u_sincos_pt (
      .clock(clock), .en(pe), .angle(p0_ff.t), .cos_out(pt_cos), .sin_out(pt_sin));

   always_comb begin
      logic signed [64:0] mu, mv;
      q1_in    = pd_ff[SC_LAT-1];
      mu       = $signed({1'b0, q1_in.a}) * pt_cos;
      mv       = $signed({1'b0, q1_in.b}) * pt_sin;
      q1_in.ua = mu[63:0];
      q1_in.vb = mv[63:0];
   end

   always_comb begin
      logic signed [63:0] ru, rv;
      q2_in    = q1_ff;
      ru       = (q1_ff.ua + 64'sd536870912) >>> 30;
      rv       = (q1_ff.vb + 64'sd536870912) >>> 30;
      q2_in.uu = ru[31:0];
      q2_in.vv = rv[31:0];
   end

   always_comb begin
      logic signed [63:0] m1, m2, m3, m4;
      q3_in    = q2_ff;
      m1       = q2_ff.uu * q2_ff.ca;
      m2       = q2_ff.vv * q2_ff.sa;
      m3       = q2_ff.uu * q2_ff.sa;
      m4       = q2_ff.vv * q2_ff.ca;
      q3_in.xa = m1;
      q3_in.xb = m2;
      q3_in.ya = m3;
      q3_in.yb = m4;
   end

   always_comb begin
      logic signed [63:0] sx, sy;
      q4_in    = q3_ff;
      sx       = (q3_ff.xa - q3_ff.xb + 64'sd536870912) >>> 30;
      sy       = (q3_ff.ya + q3_ff.yb + 64'sd536870912) >>> 30;
      q4_in.xi = sx[33:0];
      q4_in.yi = sy[33:0];
   end

   always_comb begin
      logic signed [34:0] sx, sy;
      out_in = q4_ff;
      sx     = 35'(q4_ff.mx) + 35'(q4_ff.xi);
      sy     = 35'(q4_ff.my) + 35'(q4_ff.yi);
      if (sx > 35'sd2147483647)       out_in.px = 32'h7FFF_FFFF;
      else if (sx < -35'sd2147483648) out_in.px = 32'h8000_0000;
      else                            out_in.px = sx[31:0];
      if (sy > 35'sd2147483647)       out_in.py = 32'h7FFF_FFFF;
      else if (sy < -35'sd2147483648) out_in.py = 32'h8000_0000;
      else                            out_in.py = sy[31:0];
      if (q4_ff.status != ST_OK) begin
         out_in.px = '0;
         out_in.py = '0;
      end
   end

   assign pe = !out_ff.vld || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SC_LAT; j++) pd_ff[j].vld <= 1'b0;
         q1_ff.vld  <= 1'b0;
         q2_ff.vld  <= 1'b0;
         q3_ff.vld  <= 1'b0;
         q4_ff.vld  <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (pe) begin
         pd_ff[0] <= p0_ff;
         for (int j = 1; j < SC_LAT; j++) pd_ff[j] <= pd_ff[j-1];
         q1_ff  <= q1_in;
         q2_ff  <= q2_in;
         q3_ff  <= q3_in;
         q4_ff  <= q4_in;
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_ff.vld;
   assign rsp_tdata  = {2'b00, out_ff.k, out_ff.mz, out_ff.py, out_ff.px};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.status;

endmodule
